// File: rtl/apor_pkg.sv
package apor_pkg;

    localparam int MAX_BOXES = 8;
    localparam int CELL_W    = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CMP_W     = (CELL_W + 1 > 4) ? CELL_W + 1 : 4;
    localparam int COORD_W   = 16;
    localparam int EXT_W     = 18;
    localparam int HALF_W    = 12;
    localparam int GROW_W    = 13;
    localparam int HITS_W    = 4;
    localparam int MARGIN_W  = 8;
    localparam int ENTRIES_W = 4;
    localparam int CFG_IDX_W = 1;

    localparam logic [MARGIN_W-1:0] MARGIN_RESET  = 8'd8;
    localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 4'd0;
    localparam logic [HITS_W-1:0]   HITS_MAX      = 4'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PUSH_MARGIN = 1'b0,
        CFG_ENTRIES     = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        OP_WRITE   = 1'b0,
        OP_RESOLVE = 1'b1
    } t_op;

    typedef struct packed {
        t_op                       op;
        logic [2:0]                entry_index;
        logic signed [COORD_W-1:0] box_x;
        logic signed [COORD_W-1:0] box_z;
        logic [HALF_W-1:0]         half_width;
        logic [HALF_W-1:0]         half_depth;
        logic                      box_active;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] pz;
        logic [GROW_W-1:0]         grow;
        logic [HITS_W-1:0]         hits;
    } t_item;

    function automatic logic signed [COORD_W-1:0] sat16(input logic signed [EXT_W-1:0] v);
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] lo;
        hi = EXT_W'(32767);
        lo = -EXT_W'(32768);
        if (v > hi) begin
            sat16 = 16'sh7fff;
        end else if (v < lo) begin
            sat16 = 16'sh8000;
        end else begin
            sat16 = v[COORD_W-1:0];
        end
    endfunction

endpackage

// File: rtl/apor_in_if.sv
interface apor_in_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [2:0]  entry_index;
    logic [15:0] box_x;
    logic [15:0] box_z;
    logic [11:0] half_width;
    logic [11:0] half_depth;
    logic        box_active;
    logic [15:0] point_x;
    logic [15:0] point_z;
    logic [11:0] body_radius;

    modport source (
        output valid, operation, entry_index, box_x, box_z, half_width, half_depth,
               box_active, point_x, point_z, body_radius,
        input  ready
    );
    modport sink (
        input  valid, operation, entry_index, box_x, box_z, half_width, half_depth,
               box_active, point_x, point_z, body_radius,
        output ready
    );
endinterface

// File: rtl/apor_out_if.sv
interface apor_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_x;
    logic [15:0] out_z;
    logic [3:0]  hit_count;

    modport source (
        output valid, out_x, out_z, hit_count,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_z, hit_count,
        output ready
    );
endinterface

// File: rtl/apor_cell.sv
module apor_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  logic [apor_pkg::CELL_W-1:0]     i_cell_index,
    input  logic [apor_pkg::ENTRIES_W-1:0]  i_entries,
    input  logic                            i_vld,
    input  apor_pkg::t_item                 i_item,
    output logic                            o_vld,
    output apor_pkg::t_item                 o_item
);

    logic                                   r_act;
    logic signed [apor_pkg::COORD_W-1:0]    r_bx;
    logic signed [apor_pkg::COORD_W-1:0]    r_bz;
    logic [apor_pkg::HALF_W-1:0]            r_hw;
    logic [apor_pkg::HALF_W-1:0]            r_hd;
    logic                                   r_vld;
    apor_pkg::t_item                        r_item;
    apor_pkg::t_item                        n_item;

    logic                                   w_match;
    logic                                   w_used;
    logic signed [apor_pkg::EXT_W-1:0]      w_px;
    logic signed [apor_pkg::EXT_W-1:0]      w_pz;
    logic signed [apor_pkg::EXT_W-1:0]      w_ext_x;
    logic signed [apor_pkg::EXT_W-1:0]      w_ext_z;
    logic signed [apor_pkg::EXT_W-1:0]      w_lo_x;
    logic signed [apor_pkg::EXT_W-1:0]      w_hi_x;
    logic signed [apor_pkg::EXT_W-1:0]      w_lo_z;
    logic signed [apor_pkg::EXT_W-1:0]      w_hi_z;
    logic signed [apor_pkg::EXT_W-1:0]      w_pl;
    logic signed [apor_pkg::EXT_W-1:0]      w_pr;
    logic signed [apor_pkg::EXT_W-1:0]      w_pf;
    logic signed [apor_pkg::EXT_W-1:0]      w_pb;
    logic signed [apor_pkg::EXT_W-1:0]      w_b1;
    logic signed [apor_pkg::EXT_W-1:0]      w_b2;
    logic                                   w_sel_r;
    logic                                   w_sel_f;
    logic                                   w_sel_b;
    logic                                   w_inside;

    assign w_match = apor_pkg::CMP_W'(i_item.entry_index) == apor_pkg::CMP_W'(i_cell_index);
    assign w_used  = r_act
                     && (apor_pkg::CMP_W'(i_cell_index) < apor_pkg::CMP_W'(i_entries));

    assign w_px    = apor_pkg::EXT_W'(i_item.px);
    assign w_pz    = apor_pkg::EXT_W'(i_item.pz);
    assign w_ext_x = $signed(apor_pkg::EXT_W'(r_hw)) + $signed(apor_pkg::EXT_W'(i_item.grow));
    assign w_ext_z = $signed(apor_pkg::EXT_W'(r_hd)) + $signed(apor_pkg::EXT_W'(i_item.grow));
    assign w_lo_x  = apor_pkg::EXT_W'(r_bx) - w_ext_x;
    assign w_hi_x  = apor_pkg::EXT_W'(r_bx) + w_ext_x;
    assign w_lo_z  = apor_pkg::EXT_W'(r_bz) - w_ext_z;
    assign w_hi_z  = apor_pkg::EXT_W'(r_bz) + w_ext_z;

    assign w_pl = w_px - w_lo_x;
    assign w_pr = w_hi_x - w_px;
    assign w_pf = w_pz - w_lo_z;
    assign w_pb = w_hi_z - w_pz;

    assign w_inside = (w_pl > 0) && (w_pr > 0) && (w_pf > 0) && (w_pb > 0);

    // least penetration, ties go left, right, front, back
    assign w_sel_r = w_pr < w_pl;
    assign w_b1    = w_sel_r ? w_pr : w_pl;
    assign w_sel_f = w_pf < w_b1;
    assign w_b2    = w_sel_f ? w_pf : w_b1;
    assign w_sel_b = w_pb < w_b2;

    always_comb begin
        n_item = i_item;
        if (i_item.op == apor_pkg::OP_RESOLVE && w_used && w_inside) begin
            if (w_sel_b) begin
                n_item.pz = apor_pkg::sat16(w_hi_z);
            end else if (w_sel_f) begin
                n_item.pz = apor_pkg::sat16(w_lo_z);
            end else if (w_sel_r) begin
                n_item.px = apor_pkg::sat16(w_hi_x);
            end else begin
                n_item.px = apor_pkg::sat16(w_lo_x);
            end
            if (i_item.hits != apor_pkg::HITS_MAX) begin
                n_item.hits = i_item.hits + apor_pkg::HITS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_act <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
            if (i_vld && i_item.op == apor_pkg::OP_WRITE && w_match) begin
                r_act <= i_item.box_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item <= n_item;
            if (i_vld && i_item.op == apor_pkg::OP_WRITE && w_match) begin
                r_bx <= i_item.box_x;
                r_bz <= i_item.box_z;
                r_hw <= i_item.half_width;
                r_hd <= i_item.half_depth;
            end
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

// File: rtl/aabb_push_out_resolver_unit.sv
// an accepted beat passes through the registered cells of the chain and then the output register
// throughput: one beat per cycle while the result side is not stalled
// the chain holds one cell per box; a result stall freezes the whole chain
// write beats travel the chain and load their cell on the way, giving no result
// synchronous active-low reset clears beat valids and box active marks,
// push_margin to 8 and entries_in_use to 0
module aabb_push_out_resolver_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [apor_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [apor_pkg::MARGIN_W-1:0]      i_cfg_data,
    apor_in_if.sink                            i_req,
    apor_out_if.source                         o_rsp
);

    logic [apor_pkg::MARGIN_W-1:0]   r_margin;
    logic [apor_pkg::ENTRIES_W-1:0]  r_entries;
    logic                            r_out_vld;
    apor_pkg::t_item                 r_out;
    logic                            w_adv;
    apor_pkg::t_item                 w_in;
    logic                            w_vld  [apor_pkg::MAX_BOXES+1];
    apor_pkg::t_item                 w_item [apor_pkg::MAX_BOXES+1];

    assign w_adv       = !r_out_vld || o_rsp.ready;
    assign i_req.ready = w_adv;

    always_comb begin
        w_in             = '0;
        w_in.op          = apor_pkg::t_op'(i_req.operation);
        w_in.entry_index = i_req.entry_index;
        w_in.box_x       = i_req.box_x;
        w_in.box_z       = i_req.box_z;
        w_in.half_width  = i_req.half_width;
        w_in.half_depth  = i_req.half_depth;
        w_in.box_active  = i_req.box_active;
        w_in.px          = i_req.point_x;
        w_in.pz          = i_req.point_z;
        w_in.grow        = apor_pkg::GROW_W'(i_req.body_radius)
                           + apor_pkg::GROW_W'(r_margin);
        w_in.hits        = '0;
    end

    assign w_vld[0]  = i_req.valid;
    assign w_item[0] = w_in;

    for (genvar k = 0; k < apor_pkg::MAX_BOXES; k++) begin : g_cell
        apor_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_adv        (w_adv),
            .i_cell_index (apor_pkg::CELL_W'(k)),
            .i_entries    (r_entries),
            .i_vld        (w_vld[k]),
            .i_item       (w_item[k]),
            .o_vld        (w_vld[k+1]),
            .o_item       (w_item[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin  <= apor_pkg::MARGIN_RESET;
            r_entries <= apor_pkg::ENTRIES_RESET;
        end else if (i_cfg_we) begin
            case (apor_pkg::t_cfg_idx'(i_cfg_idx))
                apor_pkg::CFG_PUSH_MARGIN: r_margin  <= i_cfg_data;
                apor_pkg::CFG_ENTRIES:     r_entries <= i_cfg_data[apor_pkg::ENTRIES_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_vld[apor_pkg::MAX_BOXES]
                         && w_item[apor_pkg::MAX_BOXES].op == apor_pkg::OP_RESOLVE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_item[apor_pkg::MAX_BOXES];
        end
    end

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.out_x     = r_out.px;
    assign o_rsp.out_z     = r_out.pz;
    assign o_rsp.hit_count = r_out.hits;

`ifndef SYNTH
    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_vld[apor_pkg::MAX_BOXES]
         && w_item[apor_pkg::MAX_BOXES].op == apor_pkg::OP_WRITE) |=> !o_rsp.valid)
        else $error("write beat produced a result");

    a_hits_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.hit_count <= r_entries))
        else $error("hit count above entries in use");

    a_stall_freezes_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(w_vld[apor_pkg::MAX_BOXES])
                    && $stable(w_item[apor_pkg::MAX_BOXES])))
        else $error("chain moved while result stalled");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import apor_pkg::*;

    localparam int LATENCY        = MAX_BOXES + 1;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_BEATS    = 200;
    localparam int PHASES         = 8;
    localparam int PRINT_LIMIT    = 50;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    typedef struct {
        t_op                op;
        logic [2:0]         idx;
        logic signed [15:0] bx;
        logic signed [15:0] bz;
        logic [11:0]        hw;
        logic [11:0]        hd;
        logic               act;
        logic signed [15:0] px;
        logic signed [15:0] pz;
        logic [11:0]        radius;
    } t_req_beat;

    typedef struct {
        logic [15:0] x;
        logic [15:0] z;
        logic [3:0]  hits;
    } t_point;

    typedef struct {
        int x;
        int z;
        int hw;
        int hd;
        bit active;
    } t_box;

    class t_push_out_scoreboard;
        t_box       boxes[MAX_BOXES];
        logic [7:0] margin;
        logic [3:0] entries;
        t_point     expected_points[$];
        int         errors;
        int         writes;
        int         resolves;
        int         checked;
        int         pushes;
        int         deepest;

        function new();
            foreach (boxes[i]) boxes[i] = '{0, 0, 0, 0, 1'b0};
            margin   = MARGIN_RESET;
            entries  = ENTRIES_RESET;
            errors   = 0;
            writes   = 0;
            resolves = 0;
            checked  = 0;
            pushes   = 0;
            deepest  = 0;
        endfunction

        function int clamp_coord(int v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [7:0] v);
            case (idx)
                CFG_PUSH_MARGIN: margin = v;
                CFG_ENTRIES:     entries = v[3:0];
                default: ;
            endcase
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PRINT_LIMIT) $display("[%0t] %s", $time, msg);
        endtask

        function void accept_beat(t_req_beat b);
            int     px, pz, grow, span, hits, i;
            int     lo_x, hi_x, lo_z, hi_z, pl, pr, pf, pb, best, dx, dz;
            t_point p;
            if (b.op == OP_WRITE) begin
                boxes[b.idx] = '{int'(b.bx), int'(b.bz), int'(b.hw), int'(b.hd), b.act};
                writes++;
                return;
            end
            resolves++;
            px   = int'(b.px);
            pz   = int'(b.pz);
            grow = int'(b.radius) + int'(margin);
            span = (int'(entries) > MAX_BOXES) ? MAX_BOXES : int'(entries);
            hits = 0;
            for (i = 0; i < span; i++) begin
                if (!boxes[i].active) continue;
                lo_x = boxes[i].x - boxes[i].hw - grow;
                hi_x = boxes[i].x + boxes[i].hw + grow;
                lo_z = boxes[i].z - boxes[i].hd - grow;
                hi_z = boxes[i].z + boxes[i].hd + grow;
                if (px <= lo_x || px >= hi_x || pz <= lo_z || pz >= hi_z) continue;
                pl   = px - lo_x;
                pr   = hi_x - px;
                pf   = pz - lo_z;
                pb   = hi_z - pz;
                // ties go left, right, front, back
                best = pl;
                dx   = -pl;
                dz   = 0;
                if (pr < best) begin
                    best = pr;
                    dx   = pr;
                    dz   = 0;
                end
                if (pf < best) begin
                    best = pf;
                    dx   = 0;
                    dz   = -pf;
                end
                if (pb < best) begin
                    dx = 0;
                    dz = pb;
                end
                px = clamp_coord(px + dx);
                pz = clamp_coord(pz + dz);
                if (hits < 15) hits++;
            end
            pushes += hits;
            if (hits > deepest) deepest = hits;
            p.x    = 16'(px);
            p.z    = 16'(pz);
            p.hits = 4'(hits);
            expected_points.push_back(p);
        endfunction

        task check_point(logic [15:0] x, logic [15:0] z, logic [3:0] hits);
            t_point want;
            if (expected_points.size() == 0) begin
                report($sformatf("unexpected result beat x %0d z %0d hits %0d",
                                 $signed(x), $signed(z), hits));
                return;
            end
            want = expected_points.pop_front();
            checked++;
            if (x !== want.x) begin
                report($sformatf("result %0d: x %0d, want %0d",
                                 checked, $signed(x), $signed(want.x)));
            end
            if (z !== want.z) begin
                report($sformatf("result %0d: z %0d, want %0d",
                                 checked, $signed(z), $signed(want.z)));
            end
            if (hits !== want.hits) begin
                report($sformatf("result %0d: hit count %0d, want %0d",
                                 checked, hits, want.hits));
            end
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [MARGIN_W-1:0]  cfg_data;
    logic                 rsp_ready = 1'b0;
    t_stall_mode          stall_mode = STALL_NONE;
    int                   stall_left = 0;
    int                   idle_cycles = 0;
    int                   settings_used = 0;
    t_push_out_scoreboard sb;

    apor_in_if  req_if ();
    apor_out_if rsp_if ();

    assign rsp_if.ready = rsp_ready;

    aabb_push_out_resolver_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_left <= $urandom_range(16, 96);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            STALL_NONE:  rsp_ready <= 1'b1;
            STALL_LIGHT: rsp_ready <= ($urandom_range(0, 3) != 0);
            STALL_HEAVY: rsp_ready <= ($urandom_range(0, 3) == 0);
            default:     rsp_ready <= (stall_left % 5 != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_ready) begin
            sb.check_point(rsp_if.out_x, rsp_if.out_z, rsp_if.hit_count);
        end
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_req_beat noise_beat();
        t_req_beat b;
        b.op     = t_op'($urandom_range(0, 1));
        b.idx    = 3'($urandom);
        b.bx     = 16'($urandom);
        b.bz     = 16'($urandom);
        b.hw     = 12'($urandom);
        b.hd     = 12'($urandom);
        b.act    = 1'($urandom);
        b.px     = 16'($urandom);
        b.pz     = 16'($urandom);
        b.radius = 12'($urandom);
        return b;
    endfunction

    function automatic t_req_beat mk_write(int idx, int x, int z, int hw, int hd, bit act);
        t_req_beat b;
        b        = noise_beat();
        b.op     = OP_WRITE;
        b.idx    = 3'(idx);
        b.bx     = 16'(x);
        b.bz     = 16'(z);
        b.hw     = 12'(hw);
        b.hd     = 12'(hd);
        b.act    = act;
        return b;
    endfunction

    function automatic t_req_beat mk_resolve(int x, int z, int r);
        t_req_beat b;
        b        = noise_beat();
        b.op     = OP_RESOLVE;
        b.px     = 16'(x);
        b.pz     = 16'(z);
        b.radius = 12'(r);
        return b;
    endfunction

    function automatic t_req_beat rand_write();
        t_req_beat b;
        int        t;
        b    = noise_beat();
        b.op = OP_WRITE;
        case ($urandom_range(0, 9))
            0: ;
            1: begin
                t    = $urandom_range(0, 4000);
                b.bx = ($urandom_range(0, 1) != 0) ? 16'(32767 - t) : 16'(t - 32768);
                t    = $urandom_range(0, 4000);
                b.bz = ($urandom_range(0, 1) != 0) ? 16'(32767 - t) : 16'(t - 32768);
            end
            default: begin
                // clustered near the origin so pushes chain through several boxes
                t    = $urandom_range(0, 4000);
                b.bx = 16'(t - 2000);
                t    = $urandom_range(0, 4000);
                b.bz = 16'(t - 2000);
                b.hw = 12'($urandom_range(0, 1500));
                b.hd = 12'($urandom_range(0, 1500));
            end
        endcase
        b.act = ($urandom_range(0, 7) != 0);
        return b;
    endfunction

    function automatic t_req_beat rand_resolve();
        t_req_beat b;
        int        k, reach, t;
        b    = noise_beat();
        b.op = OP_RESOLVE;
        if ($urandom_range(0, 9) != 0) b.radius = 12'($urandom_range(0, 600));
        if ($urandom_range(0, 7) != 0) begin
            k     = $urandom_range(0, MAX_BOXES - 1);
            reach = sb.boxes[k].hw + int'(b.radius) + int'(sb.margin) + 16;
            t     = $urandom_range(0, 2 * reach);
            b.px  = 16'(sb.clamp_coord(sb.boxes[k].x - reach + t));
            reach = sb.boxes[k].hd + int'(b.radius) + int'(sb.margin) + 16;
            t     = $urandom_range(0, 2 * reach);
            b.pz  = 16'(sb.clamp_coord(sb.boxes[k].z - reach + t));
        end
        return b;
    endfunction

    task automatic send_beat(t_req_beat b);
        req_if.valid       <= 1'b1;
        req_if.operation   <= b.op;
        req_if.entry_index <= b.idx;
        req_if.box_x       <= b.bx;
        req_if.box_z       <= b.bz;
        req_if.half_width  <= b.hw;
        req_if.half_depth  <= b.hd;
        req_if.box_active  <= b.act;
        req_if.point_x     <= b.px;
        req_if.point_z     <= b.pz;
        req_if.body_radius <= b.radius;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.accept_beat(b);
    endtask

    task automatic write_regs(logic [7:0] margin, logic [3:0] entries);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_PUSH_MARGIN;
        cfg_data <= margin;
        @(posedge i_clk);
        sb.set_reg(CFG_PUSH_MARGIN, margin);
        cfg_idx  <= CFG_ENTRIES;
        cfg_data <= {4'd0, entries};
        @(posedge i_clk);
        sb.set_reg(CFG_ENTRIES, {4'd0, entries});
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // hold input, let every pending result out, then let trailing write beats clear the chain
    task automatic settle();
        req_if.valid <= 1'b0;
        while (sb.expected_points.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic run_directed();
        send_beat(mk_write(0, 0, 0, 100, 50, 1'b1));
        send_beat(mk_write(1, 0, 0, 80, 80, 1'b1));
        send_beat(mk_write(2, -32000, 0, 0, 0, 1'b1));
        send_beat(mk_write(3, 0, 0, 4095, 4095, 1'b0));
        send_beat(mk_write(6, -32768, 32000, 4095, 0, 1'b1));
        send_beat(mk_write(7, 32000, -32768, 0, 4095, 1'b1));
        send_beat(mk_resolve(10, 0, 0));
        send_beat(mk_resolve(0, 0, 0));
        send_beat(mk_resolve(-100, 0, 0));
        send_beat(mk_resolve(32767, -32768, 4095));
        send_beat(mk_resolve(-32768, 32767, 4095));
        send_beat(mk_resolve(-32768, 0, 4095));
        send_beat(mk_resolve(32767, 32767, 4095));
        send_beat(mk_resolve(-32768, -32768, 0));
        send_beat(mk_resolve(5, 5, 4095));
        send_beat(mk_write(0, 0, 0, 100, 50, 1'b0));
        send_beat(mk_resolve(10, 0, 0));
        send_beat(mk_write(4, 32767, -32768, 4095, 4095, 1'b1));
        send_beat(mk_write(5, -32768, 32767, 4095, 4095, 1'b1));
        send_beat(mk_resolve(0, 0, 1000));
    endtask

    task automatic run_phase(int count);
        int        burst, gap, k;
        t_req_beat b;
        burst = $urandom_range(1, 40);
        for (k = 0; k < count; k++) begin
            b = ($urandom_range(0, 3) == 0) ? rand_write() : rand_resolve();
            send_beat(b);
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 40);
                gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                if (gap != 0) begin
                    req_if.valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end
    endtask

    initial begin
        int         ph;
        logic [7:0] margin;
        logic [3:0] entries;
        sb = new();
        i_rst_n            <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= CFG_PUSH_MARGIN;
        cfg_data           <= '0;
        req_if.valid       <= 1'b0;
        req_if.operation   <= OP_WRITE;
        req_if.entry_index <= '0;
        req_if.box_x       <= '0;
        req_if.box_z       <= '0;
        req_if.half_width  <= '0;
        req_if.half_depth  <= '0;
        req_if.box_active  <= 1'b0;
        req_if.point_x     <= '0;
        req_if.point_z     <= '0;
        req_if.body_radius <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_regs(8'd0, 4'd8);
        run_directed();
        settle();

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    margin  = 8'd255;
                    entries = 4'd8;
                end
                1: begin
                    margin  = MARGIN_RESET;
                    entries = 4'd8;
                end
                2: begin
                    margin  = 8'd0;
                    entries = 4'd15;
                end
                3: begin
                    margin  = 8'($urandom);
                    entries = 4'd9;
                end
                4: begin
                    margin  = 8'($urandom);
                    entries = 4'd0;
                end
                5: begin
                    margin  = 8'($urandom);
                    entries = 4'($urandom_range(1, 7));
                end
                6: begin
                    margin  = 8'd1;
                    entries = 4'd8;
                end
                default: begin
                    margin  = 8'($urandom);
                    entries = 4'd8;
                end
            endcase
            write_regs(margin, entries);
            run_phase(PHASE_BEATS);
            settle();
        end

        if (sb.expected_points.size() != 0) begin
            sb.report($sformatf("%0d results never arrived", sb.expected_points.size()));
        end
        $display("covered %0d table writes and %0d resolves over %0d register settings",
                 sb.writes, sb.resolves, settings_used);
        $display("%0d results checked, %0d push-outs, up to %0d boxes hit by one point",
                 sb.checked, sb.pushes, sb.deepest);
        if (sb.errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
